// ----- hw/rtl/foreground_depth_patch_filter_macros.svh -----
// Assertion macros for the foreground depth patch filter.
// Used by the top-level RTL file, which checks its own control logic; needs no package.
`ifndef FOREGROUND_DEPTH_PATCH_FILTER_MACROS_SVH
`define FOREGROUND_DEPTH_PATCH_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Check that the consequent holds in the same cycle as the antecedent.
`define FDPF_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fdpf assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define FDPF_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fdpf assertion failed");

`else

`define FDPF_ASSERT_IMP(lbl, ante, cons)
`define FDPF_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- hw/rtl/fdpf_pkg.sv -----
// Package of the foreground depth patch filter: widths, register indexes,
// reset values and the control struct of the sorting cells. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fdpf_pkg;

   localparam int DEPTH_BITS_DEF = 16;
   localparam int STORE_DEPTH    = 25;
   localparam int CNT_W          = 5;
   localparam int COORD_W        = 14;
   localparam int DIM_W          = 13;
   localparam int MIN_DEPTH_W    = 16;
   localparam int MIN_CNT_W      = 5;
   localparam int DIV_W          = 8;
   localparam int CSR_W          = 16;
   localparam int CSR_IDX_W      = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DEPTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_COUNT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_DIV     = 3'd4;

   localparam logic [DIM_W-1:0]       RST_IMAGE_WIDTH  = 13'd640;
   localparam logic [DIM_W-1:0]       RST_IMAGE_HEIGHT = 13'd480;
   localparam logic [MIN_DEPTH_W-1:0] RST_MIN_DEPTH    = 16'd200;
   localparam logic [MIN_CNT_W-1:0]   RST_MIN_COUNT    = 5'd8;
   localparam logic [DIV_W-1:0]       RST_JUMP_DIV     = 8'd20;

   // What every cell of the chain does in a cycle.
   typedef struct packed {
      logic insert;  // sorted insert of the new depth
      logic shift;   // move every value one cell toward the head
      logic eval;    // latch the relative jump flag against the left neighbor
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/fdpf_cell.sv -----
// One cell of the sorted depth chain: holds one depth, takes part in the
// sorted insert, shifts toward the head and flags a jump. Uses fdpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdpf_cell #(
   parameter int DEPTH_BITS = fdpf_pkg::DEPTH_BITS_DEF
) (
   input  wire                          clock,
   input  fdpf_pkg::cell_ctrl_type      ctrl,
   input  wire                          occupied,
   input  wire  [DEPTH_BITS-1:0]        new_depth,
   input  wire  [DEPTH_BITS-1:0]        left_value,
   input  wire                          left_gt,
   input  wire  [DEPTH_BITS-1:0]        right_value,
   input  wire  [fdpf_pkg::DIV_W-1:0]   jump_div,
   output logic [DEPTH_BITS-1:0]        value,
   output logic                         gt,
   output logic                         jump
);

   localparam int PROD_W = DEPTH_BITS + fdpf_pkg::DIV_W;

   logic [DEPTH_BITS-1:0] value_ff, value_in;
   logic                  jump_ff, jump_in;
   logic [DEPTH_BITS-1:0] diff;
   logic [PROD_W-1:0]     prod;

   assign gt = occupied && (value_ff > new_depth);

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         // take the left value when it moves right, the new depth at the insert spot
         if (left_gt) begin
            value_in = left_value;
         end else if (!occupied || gt) begin
            value_in = new_depth;
         end
      end else if (ctrl.shift) begin
         value_in = right_value;
      end
   end

   assign diff = value_ff - left_value;
   assign prod = {{fdpf_pkg::DIV_W{1'b0}}, diff} * {{DEPTH_BITS{1'b0}}, jump_div};
   assign jump_in = ctrl.eval ? (prod > {{fdpf_pkg::DIV_W{1'b0}}, left_value}) : jump_ff;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      jump_ff  <= jump_in;
   end

   assign value = value_ff;
   assign jump  = jump_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/foreground_depth_patch_filter.sv -----
// Top level of the foreground depth patch filter: configuration registers,
// sample qualification, chain of fdpf_cell and the result sequencer.
// Uses fdpf_pkg, fdpf_cell and foreground_depth_patch_filter_macros.svh.
//
// Usage:
//   Samples of one patch enter on req_*; an item is taken at a clock edge with
//   start high and busy low. In-image samples deeper than min_depth are
//   placed in sorted order into a chain of 25 cells, one sample per cycle with
//   busy low, so a patch streams in at one item per cycle.
//   The item with req_last_sample set ends the patch: busy rises while the
//   chain latches its jump flags, the cut is found and the sorted depths
//   shift out through the head cell until the cut is reached (no shifting
//   when too few samples are valid), then the result is formed. rsp_valid
//   pulses for one cycle together with the registered result. busy is low
//   again in the cycle of rsp_valid, and the next item may be taken then.
//   The result fields hold until the next result, but rsp_valid is high for
//   one cycle only; the receiver cannot stall. The user must see that
//   registers are written through csr_* while busy is low and no patch is
//   open; the block does not enforce this. Reset returns the registers to
//   their defaults and empties the chain.
`timescale 1ns / 1ps
`default_nettype none
`include "foreground_depth_patch_filter_macros.svh"

module foreground_depth_patch_filter #(
   parameter int DEPTH_BITS = fdpf_pkg::DEPTH_BITS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire  [DEPTH_BITS-1:0]                req_depth_mm,
   input  wire  signed [fdpf_pkg::COORD_W-1:0]  req_sample_col,
   input  wire  signed [fdpf_pkg::COORD_W-1:0]  req_sample_row,
   input  wire                                  req_is_center,
   input  wire                                  req_last_sample,
   input  wire                                  csr_we,
   input  wire  [fdpf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [fdpf_pkg::CSR_W-1:0]           csr_wdata,
   output logic                                 rsp_valid,
   output logic [DEPTH_BITS:0]                  rsp_corr_depth,
   output logic                                 rsp_depth_found,
   output logic [fdpf_pkg::CNT_W-1:0]           rsp_valid_count,
   output logic [fdpf_pkg::CNT_W-1:0]           rsp_foreground_count
);

   localparam int CNT_W = fdpf_pkg::CNT_W;
   localparam int NCELL = fdpf_pkg::STORE_DEPTH;
   localparam int CMP_W = (DEPTH_BITS > fdpf_pkg::MIN_DEPTH_W) ?
                          DEPTH_BITS : fdpf_pkg::MIN_DEPTH_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EVAL = 3'd1;
   localparam logic [2:0] ST_CUT  = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   // configuration registers
   logic [fdpf_pkg::DIM_W-1:0]       img_width_ff, img_height_ff;
   logic [fdpf_pkg::MIN_DEPTH_W-1:0] min_depth_ff;
   logic [fdpf_pkg::MIN_CNT_W-1:0]   min_count_ff;
   logic [fdpf_pkg::DIV_W-1:0]       jump_div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff  <= fdpf_pkg::RST_IMAGE_WIDTH;
         img_height_ff <= fdpf_pkg::RST_IMAGE_HEIGHT;
         min_depth_ff  <= fdpf_pkg::RST_MIN_DEPTH;
         min_count_ff  <= fdpf_pkg::RST_MIN_COUNT;
         jump_div_ff   <= fdpf_pkg::RST_JUMP_DIV;
      end else if (csr_we) begin
         case (csr_index)
            fdpf_pkg::CSR_IMAGE_WIDTH: begin
               img_width_ff <= csr_wdata[fdpf_pkg::DIM_W-1:0];
            end
            fdpf_pkg::CSR_IMAGE_HEIGHT: begin
               img_height_ff <= csr_wdata[fdpf_pkg::DIM_W-1:0];
            end
            fdpf_pkg::CSR_MIN_DEPTH: begin
               min_depth_ff <= csr_wdata[fdpf_pkg::MIN_DEPTH_W-1:0];
            end
            fdpf_pkg::CSR_MIN_COUNT: begin
               min_count_ff <= csr_wdata[fdpf_pkg::MIN_CNT_W-1:0];
            end
            fdpf_pkg::CSR_JUMP_DIV: begin
               jump_div_ff <= csr_wdata[fdpf_pkg::DIV_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // control state
   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      cut_ff, cut_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  found_ff, found_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DEPTH_BITS-1:0] center_ff, center_in;

   // captured values of the foreground part
   logic [DEPTH_BITS-1:0] first_ff, last_ff, mlo_ff, mhi_ff;
   logic [DEPTH_BITS:0]   adj_ff;
   logic                  dfound_ff;
   logic [CNT_W-1:0]      vcount_ff, fgcount_ff;

   logic accept, in_image, sample_ok, do_insert;
   logic [CNT_W-1:0] cut_sel, half;
   logic             enough;
   logic             in_part;
   logic [DEPTH_BITS:0] adj_sel;

   fdpf_pkg::cell_ctrl_type ctrl;

   logic [DEPTH_BITS-1:0] cell_value [NCELL];
   logic [NCELL-1:0]      cell_gt, cell_jump, cell_occ;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign in_image = !req_sample_col[fdpf_pkg::COORD_W-1] &&
                     (req_sample_col[fdpf_pkg::DIM_W-1:0] < img_width_ff) &&
                     !req_sample_row[fdpf_pkg::COORD_W-1] &&
                     (req_sample_row[fdpf_pkg::DIM_W-1:0] < img_height_ff);
   assign sample_ok = in_image && (CMP_W'(req_depth_mm) > CMP_W'(min_depth_ff));
   assign do_insert = accept && sample_ok && (count_ff != CNT_W'(NCELL));

   assign ctrl.insert = do_insert;
   assign ctrl.shift  = (state_ff == ST_SCAN);
   assign ctrl.eval   = (state_ff == ST_EVAL);

   genvar gi;
   generate
      for (gi = 0; gi < NCELL; gi++) begin : g_cell
         logic [DEPTH_BITS-1:0] lval, rval;
         logic                  lgt;

         assign cell_occ[gi] = (count_ff > CNT_W'(gi));

         if (gi == 0) begin : g_head
            assign lval = '0;
            assign lgt  = 1'b0;
         end else begin : g_body
            assign lval = cell_value[gi-1];
            assign lgt  = cell_gt[gi-1];
         end

         if (gi == NCELL - 1) begin : g_tail
            assign rval = '0;
         end else begin : g_mid
            assign rval = cell_value[gi+1];
         end

         fdpf_cell #(
            .DEPTH_BITS (DEPTH_BITS)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (cell_occ[gi]),
            .new_depth   (req_depth_mm),
            .left_value  (lval),
            .left_gt     (lgt),
            .right_value (rval),
            .jump_div    (jump_div_ff),
            .value       (cell_value[gi]),
            .gt          (cell_gt[gi]),
            .jump        (cell_jump[gi])
         );
      end
   endgenerate

   // first jump inside the stored list; the whole list when none
   always_comb begin
      cut_sel = count_ff;
      for (int k = NCELL - 1; k >= 1; k--) begin
         if (cell_jump[k] && cell_occ[k]) begin
            cut_sel = CNT_W'(k);
         end
      end
   end

   assign enough = (count_ff != '0) &&
                   (count_ff >= CNT_W'(min_count_ff));
   assign half   = cut_ff >> 1;

   assign in_part = (center_ff >= first_ff) && (center_ff <= last_ff);

   always_comb begin
      if (in_part) begin
         adj_sel = {center_ff, 1'b0};
      end else if (cut_ff[0]) begin
         adj_sel = {mhi_ff, 1'b0};
      end else begin
         adj_sel = {1'b0, mlo_ff} + {1'b0, mhi_ff};
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cut_in       = cut_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      rsp_valid_in = 1'b0;
      center_in    = center_ff;
      if (accept && req_is_center) begin
         center_in = req_depth_mm;
      end
      if (do_insert) begin
         count_in = count_ff + 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_sample) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_CUT;
         end
         ST_CUT: begin
            cut_in   = cut_sel;
            found_in = enough;
            idx_in   = '0;
            state_in = enough ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            // stop once the last foreground value has passed the head
            if (idx_ff == cut_ff - 1'b1) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            count_in     = '0;
            center_in    = '0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         center_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         center_ff    <= center_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      cut_ff <= cut_in;
      idx_ff <= idx_in;
      if (state_ff == ST_SCAN) begin
         if (idx_ff == '0) begin
            first_ff <= cell_value[0];
         end
         if (idx_ff == cut_ff - 1'b1) begin
            last_ff <= cell_value[0];
         end
         if (idx_ff == half - 1'b1) begin
            mlo_ff <= cell_value[0];
         end
         if (idx_ff == half) begin
            mhi_ff <= cell_value[0];
         end
      end
      if (state_ff == ST_DONE) begin
         adj_ff     <= found_ff ? adj_sel : '0;
         dfound_ff  <= found_ff;
         vcount_ff  <= count_ff;
         fgcount_ff <= found_ff ? cut_ff : '0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_corr_depth       = adj_ff;
   assign rsp_depth_found      = dfound_ff;
   assign rsp_valid_count      = vcount_ff;
   assign rsp_foreground_count = fgcount_ff;

   `FDPF_ASSERT_IMP(a_resp_when_idle, rsp_valid_ff, state_ff == ST_IDLE)
   `FDPF_ASSERT_NXT(a_last_goes_busy, accept && req_last_sample, busy)
   `FDPF_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(NCELL))
   `FDPF_ASSERT_IMP(a_none_zero, rsp_valid_ff && !dfound_ff, (adj_ff == '0) && (fgcount_ff == '0))
   `FDPF_ASSERT_IMP(a_fg_range, rsp_valid_ff && dfound_ff, (fgcount_ff != '0) && (fgcount_ff <= vcount_ff))

endmodule

`default_nettype wire
